### rtl/core/gawu_pkg.sv
// ----------------------------------------------------------------------------
// gawu_pkg
// Shared types and constants for the gas alarm with warmup block.
// ----------------------------------------------------------------------------
package gawu_pkg;

   localparam int ADC_W      = 12;
   localparam int SUM_W      = 16;
   localparam int PCT_W      = 7;
   localparam int CMD_W      = 2;
   localparam int TICK_W     = 20;
   localparam int LIMIT_W    = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [TICK_W-1:0]  TICK_MAX          = '1;
   localparam logic [TICK_W-1:0]  WARMUP_MS_RESET   = 20'd120000;
   localparam logic [LIMIT_W-1:0] SMOKE_LIMIT_RESET = 7'd95;
   localparam logic [LIMIT_W-1:0] GAS_LIMIT_RESET   = 7'd30;

   // Percent scaling: pct = (avg * PERCENT) / FULL_SCALE, done as a
   // multiplication by a rounded-up reciprocal, exact for every scaled value.
   localparam int          SCALED_W   = 19;
   localparam int          PERCENT    = 100;
   localparam longint      FULL_SCALE = 4095;
   localparam int          PCT_SH     = 31;
   localparam int          PCT_MULT_W = 20;
   localparam longint      PCT_MULT   = ((64'd1 << PCT_SH) + FULL_SCALE - 1) / FULL_SCALE;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_SAMPLE  = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WARMUP_MS   = 2'd0,
      REG_SMOKE_LIMIT = 2'd1,
      REG_GAS_LIMIT   = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [TICK_W-1:0]  warmup_ms;
      logic [LIMIT_W-1:0] smoke_limit;
      logic [LIMIT_W-1:0] gas_limit;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0] smoke_sum;
      logic [SUM_W-1:0] gas_sum;
      logic             warm;
   } batch_type;

   typedef struct packed {
      logic [PCT_W-1:0] smoke_pct;
      logic [PCT_W-1:0] gas_pct;
      logic             warm;
   } pct_type;

endpackage

### rtl/core/gawu_req_if.sv
// ----------------------------------------------------------------------------
// gawu_req_if
// Input channel: commands, ticks and sample pairs with valid/ready.
// ----------------------------------------------------------------------------
interface gawu_req_if import gawu_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [ADC_W-1:0]   smoke_sample;
   logic [ADC_W-1:0]   gas_sample;

   modport source (output valid, output cmd, output smoke_sample, output gas_sample,
                   input ready);
   modport sink   (input valid, input cmd, input smoke_sample, input gas_sample,
                   output ready);
endinterface

### rtl/core/gawu_rsp_if.sv
// ----------------------------------------------------------------------------
// gawu_rsp_if
// Result channel: percentages and alarm flags with valid/ready.
// ----------------------------------------------------------------------------
interface gawu_rsp_if import gawu_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] smoke_pct;
   logic [PCT_W-1:0] gas_pct;
   logic             smoke_alarm;
   logic             gas_alarm;
   logic             buzz_alarm;
   logic             warmed_up;

   modport source (output valid, output smoke_pct, output gas_pct, output smoke_alarm,
                   output gas_alarm, output buzz_alarm, output warmed_up, input ready);
   modport sink   (input valid, input smoke_pct, input gas_pct, input smoke_alarm,
                   input gas_alarm, input buzz_alarm, input warmed_up, output ready);
endinterface

### rtl/core/gawu_csr.sv
// ----------------------------------------------------------------------------
// gawu_csr
// APB-style register file holding warmup time and alarm limits.
// ----------------------------------------------------------------------------
module gawu_csr import gawu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_ms   <= WARMUP_MS_RESET;
         cfg_ff.smoke_limit <= SMOKE_LIMIT_RESET;
         cfg_ff.gas_limit   <= GAS_LIMIT_RESET;
      end else if (wr_en) begin
         case (idx)
            REG_WARMUP_MS:   cfg_ff.warmup_ms   <= pwdata[TICK_W-1:0];
            REG_SMOKE_LIMIT: cfg_ff.smoke_limit <= pwdata[LIMIT_W-1:0];
            REG_GAS_LIMIT:   cfg_ff.gas_limit   <= pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_WARMUP_MS:   prdata = CSR_DATA_W'(cfg_ff.warmup_ms);
         REG_SMOKE_LIMIT: prdata = CSR_DATA_W'(cfg_ff.smoke_limit);
         REG_GAS_LIMIT:   prdata = CSR_DATA_W'(cfg_ff.gas_limit);
         default:         prdata = '0;
      endcase
   end

endmodule

### rtl/core/gawu_accum.sv
// ----------------------------------------------------------------------------
// gawu_accum
// Front end: tick counter, warmup state and per-batch sample sums.
// ----------------------------------------------------------------------------
module gawu_accum import gawu_pkg::*; #(
   parameter int SAMPLES_PER_AVG = 10
) (
   input  logic              clock,
   input  logic              reset,
   gawu_req_if.sink          req_chan,
   input  logic [TICK_W-1:0] warmup_ms,
   output logic              batch_valid,
   input  logic              batch_ready,
   output batch_type         batch
);

   localparam int CNT_W = $clog2(SAMPLES_PER_AVG + 1);

   logic [SUM_W-1:0]  smoke_sum_ff, smoke_sum_in;
   logic [SUM_W-1:0]  gas_sum_ff, gas_sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              warm_ff, warm_in;
   logic              batch_valid_ff, batch_valid_in;
   batch_type         batch_ff, batch_in;
   logic              accept;
   logic              batch_done;
   logic [CNT_W-1:0]  count_inc;
   logic [SUM_W-1:0]  smoke_acc, gas_acc;
   logic              warm_now;

   assign req_chan.ready = !batch_valid_ff || batch_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign batch_valid    = batch_valid_ff;
   assign batch          = batch_ff;

   assign count_inc = count_ff + CNT_W'(1);
   assign smoke_acc = smoke_sum_ff + SUM_W'(req_chan.smoke_sample);
   assign gas_acc   = gas_sum_ff + SUM_W'(req_chan.gas_sample);
   assign warm_now  = warm_ff || (ticks_ff >= warmup_ms);

   always_comb begin
      smoke_sum_in   = smoke_sum_ff;
      gas_sum_in     = gas_sum_ff;
      count_in       = count_ff;
      ticks_in       = ticks_ff;
      warm_in        = warm_ff;
      batch_done     = 1'b0;
      batch_in       = batch_ff;
      if (accept) begin
         case (req_chan.cmd)
            CMD_TICK: begin
               if (ticks_ff != TICK_MAX) ticks_in = ticks_ff + TICK_W'(1);
            end
            CMD_RESTART: begin
               ticks_in = '0;
               warm_in  = 1'b0;
            end
            CMD_SAMPLE: begin
               if (count_inc == CNT_W'(SAMPLES_PER_AVG)) begin
                  // Batch complete: hand the sums on and check warmup now.
                  batch_done         = 1'b1;
                  batch_in.smoke_sum = smoke_acc;
                  batch_in.gas_sum   = gas_acc;
                  batch_in.warm      = warm_now;
                  warm_in            = warm_now;
                  smoke_sum_in       = '0;
                  gas_sum_in         = '0;
                  count_in           = '0;
               end else begin
                  smoke_sum_in = smoke_acc;
                  gas_sum_in   = gas_acc;
                  count_in     = count_inc;
               end
            end
            default: ;
         endcase
      end
      batch_valid_in = batch_done || (batch_valid_ff && !batch_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoke_sum_ff   <= '0;
         gas_sum_ff     <= '0;
         count_ff       <= '0;
         ticks_ff       <= '0;
         warm_ff        <= 1'b0;
         batch_valid_ff <= 1'b0;
      end else begin
         smoke_sum_ff   <= smoke_sum_in;
         gas_sum_ff     <= gas_sum_in;
         count_ff       <= count_in;
         ticks_ff       <= ticks_in;
         warm_ff        <= warm_in;
         batch_valid_ff <= batch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
   end

endmodule

### rtl/core/gawu_scale.sv
// ----------------------------------------------------------------------------
// gawu_scale
// Three-stage pipeline: sum to average, average times 100, then to percent.
// ----------------------------------------------------------------------------
module gawu_scale import gawu_pkg::*; #(
   parameter int SAMPLES_PER_AVG = 10
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  batch_type in_batch,
   output logic      out_valid,
   input  logic      out_ready,
   output pct_type   out_pct
);

   // Division by the batch size through a rounded-up reciprocal; the extra
   // shift of log2(N) bits makes the result exact for every 16-bit sum.
   localparam int     DIV_SH   = SUM_W + $clog2(SAMPLES_PER_AVG);
   localparam longint DIV_MULT = ((64'd1 << DIV_SH) + SAMPLES_PER_AVG - 1) / SAMPLES_PER_AVG;
   localparam int     DIV_P_W  = SUM_W + DIV_SH + 1;
   localparam int     PCT_P_W  = SCALED_W + PCT_MULT_W;

   localparam logic [DIV_SH:0]       DIV_MULT_V = (DIV_SH + 1)'(DIV_MULT);
   localparam logic [PCT_MULT_W-1:0] PCT_MULT_V = PCT_MULT_W'(PCT_MULT);

   logic                b_valid_ff, c_valid_ff, d_valid_ff;
   logic                b_ready, c_ready, d_ready;
   logic [ADC_W-1:0]    b_smoke_ff, b_gas_ff;
   logic                b_warm_ff;
   logic [SCALED_W-1:0] c_smoke_ff, c_gas_ff;
   logic                c_warm_ff;
   pct_type             d_pct_ff;
   logic [DIV_P_W-1:0]  smoke_div_p, gas_div_p;
   logic [PCT_P_W-1:0]  smoke_pct_p, gas_pct_p;

   assign d_ready   = !d_valid_ff || out_ready;
   assign c_ready   = !c_valid_ff || d_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign in_ready  = b_ready;
   assign out_valid = d_valid_ff;
   assign out_pct   = d_pct_ff;

   assign smoke_div_p = DIV_P_W'(in_batch.smoke_sum) * DIV_P_W'(DIV_MULT_V);
   assign gas_div_p   = DIV_P_W'(in_batch.gas_sum) * DIV_P_W'(DIV_MULT_V);
   assign smoke_pct_p = PCT_P_W'(c_smoke_ff) * PCT_P_W'(PCT_MULT_V);
   assign gas_pct_p   = PCT_P_W'(c_gas_ff) * PCT_P_W'(PCT_MULT_V);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (b_ready) b_valid_ff <= in_valid;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && in_valid) begin
         b_smoke_ff <= smoke_div_p[DIV_SH +: ADC_W];
         b_gas_ff   <= gas_div_p[DIV_SH +: ADC_W];
         b_warm_ff  <= in_batch.warm;
      end
      if (c_ready && b_valid_ff) begin
         c_smoke_ff <= SCALED_W'(b_smoke_ff) * SCALED_W'(PERCENT);
         c_gas_ff   <= SCALED_W'(b_gas_ff) * SCALED_W'(PERCENT);
         c_warm_ff  <= b_warm_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_pct_ff.smoke_pct <= smoke_pct_p[PCT_SH +: PCT_W];
         d_pct_ff.gas_pct   <= gas_pct_p[PCT_SH +: PCT_W];
         d_pct_ff.warm      <= c_warm_ff;
      end
   end

endmodule

### rtl/core/gawu_eval.sv
// ----------------------------------------------------------------------------
// gawu_eval
// Alarm decision, persistent alarm flags and the result register.
// ----------------------------------------------------------------------------
module gawu_eval import gawu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pct_type            in_pct,
   input  logic [LIMIT_W-1:0] smoke_limit,
   input  logic [LIMIT_W-1:0] gas_limit,
   gawu_rsp_if.source         rsp_chan
);

   logic             smoke_flag_ff, smoke_flag_in;
   logic             gas_flag_ff, gas_flag_in;
   logic             buzz_flag_ff, buzz_flag_in;
   logic             valid_ff;
   logic [PCT_W-1:0] smoke_pct_ff, gas_pct_ff;
   logic             warm_ff;
   logic             load;

   assign in_ready = !valid_ff || rsp_chan.ready;
   assign load     = in_valid && in_ready;

   // A flag not touched by the branch that applies keeps its old value.
   always_comb begin
      smoke_flag_in = smoke_flag_ff;
      gas_flag_in   = gas_flag_ff;
      buzz_flag_in  = buzz_flag_ff;
      if (load) begin
         if (!in_pct.warm) begin
            smoke_flag_in = 1'b0;
            gas_flag_in   = 1'b0;
            buzz_flag_in  = 1'b0;
         end else if (in_pct.smoke_pct > smoke_limit) begin
            smoke_flag_in = 1'b1;
            buzz_flag_in  = 1'b1;
         end else if (in_pct.gas_pct > gas_limit) begin
            gas_flag_in   = 1'b1;
            buzz_flag_in  = 1'b1;
         end else begin
            smoke_flag_in = 1'b0;
            gas_flag_in   = 1'b0;
            buzz_flag_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoke_flag_ff <= 1'b0;
         gas_flag_ff   <= 1'b0;
         buzz_flag_ff  <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         smoke_flag_ff <= smoke_flag_in;
         gas_flag_ff   <= gas_flag_in;
         buzz_flag_ff  <= buzz_flag_in;
         if (in_ready) valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         smoke_pct_ff <= in_pct.smoke_pct;
         gas_pct_ff   <= in_pct.gas_pct;
         warm_ff      <= in_pct.warm;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.smoke_pct   = smoke_pct_ff;
   assign rsp_chan.gas_pct     = gas_pct_ff;
   assign rsp_chan.smoke_alarm = smoke_flag_ff;
   assign rsp_chan.gas_alarm   = gas_flag_ff;
   assign rsp_chan.buzz_alarm  = buzz_flag_ff;
   assign rsp_chan.warmed_up   = warm_ff;

endmodule

### rtl/core/gas_alarm_with_warmup_core.sv
// ----------------------------------------------------------------------------
// gas_alarm_with_warmup_core
// Smoke and gas alarm with warmup: batch averaging, percent scaling, flags.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake      Payload
//   req_chan   in         valid/ready    cmd, smoke_sample, gas_sample
//   rsp_chan   out        valid/ready    smoke_pct, gas_pct, four flags
//   csr (APB)  in         psel/penable   warmup_ms, smoke_limit, gas_limit
//
// One item is taken per cycle while req_chan is ready. The item that completes a
// batch loads the batch register at the edge that takes it, and its result then
// passes the average multiply, the times-100 stage and the reciprocal multiply
// registers before the result register. Each stage holds while the next is full,
// so input is refused only once every stage is occupied.
// Reset is synchronous and clears counters, sums, warmup and flags.
// ----------------------------------------------------------------------------
module gas_alarm_with_warmup_core import gawu_pkg::*; #(
   parameter int SAMPLES_PER_AVG = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   gawu_req_if.sink              req_chan,
   gawu_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   logic      batch_valid, batch_ready;
   batch_type batch;
   logic      pct_valid, pct_ready;
   pct_type   pct;

   gawu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gawu_accum #(.SAMPLES_PER_AVG(SAMPLES_PER_AVG)) u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .warmup_ms   (cfg.warmup_ms),
      .batch_valid (batch_valid),
      .batch_ready (batch_ready),
      .batch       (batch)
   );

   gawu_scale #(.SAMPLES_PER_AVG(SAMPLES_PER_AVG)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (batch_valid),
      .in_ready  (batch_ready),
      .in_batch  (batch),
      .out_valid (pct_valid),
      .out_ready (pct_ready),
      .out_pct   (pct)
   );

   gawu_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pct_valid),
      .in_ready    (pct_ready),
      .in_pct      (pct),
      .smoke_limit (cfg.smoke_limit),
      .gas_limit   (cfg.gas_limit),
      .rsp_chan    (rsp_chan)
   );

endmodule
